### rtl/core/rwdc_pkg.sv
// Shared constants and the CRC-8 byte update for the register write datagram block.
// No dependencies.
package rwdc_pkg;

  // Datagram length in bytes; the last one carries the CRC
  localparam int unsigned DGRAM_LEN   = 8;
  localparam int unsigned CNT_W       = $clog2(DGRAM_LEN);
  localparam int unsigned PAYLOAD_W   = (DGRAM_LEN - 1) * 8;

  localparam logic [7:0]  CRC_POLY    = 8'h07;
  localparam logic [7:0]  CRC_INIT    = 8'h00;
  localparam logic [7:0]  WRITE_FLAG  = 8'h80;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE = 1'b1;

  localparam logic [CNT_W-1:0] CNT_CRC = CNT_W'(DGRAM_LEN - 1);

  typedef logic [7:0] byte_t;

  // Feed one byte into the CRC, least significant bit first
  function automatic byte_t crc8_feed(input byte_t crc_in, input byte_t data);
    byte_t crc;
    byte_t b;
    logic  fb;
    crc = crc_in;
    b   = data;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[7] ^ b[0];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    return crc;
  endfunction

endpackage

### rtl/core/register_write_datagram_crc8.sv
// Register write datagram builder: framing shift register plus running CRC-8. Needs rwdc_pkg.
// The first byte passes the shift register, then the output register; eight consecutive beats.
// The shift register moves one byte per cycle; busy drops in the cycle before the CRC beat
// so the next request follows directly.
// Reset (rst_n low, synchronous): no datagram in flight, sync byte 0x05, node address 0.
// The receiver cannot stall; every beat is taken in the cycle it is shown.
module register_write_datagram_crc8
  import rwdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [6:0]           in_reg_address,
  input  logic [31:0]          in_write_value,
  // datagram byte channel
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_last_byte,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic                 act_r, act_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PAYLOAD_W-1:0] data_r, data_nxt;
  byte_t                crc_r, crc_nxt;
  byte_t                sync_r, node_r;
  logic                 oval_r, olast_r;
  byte_t                obyte_r;
  logic                 accept;
  byte_t                cur_byte;
  logic                 at_crc;

  // Accept a new request whenever no payload byte is left to send
  assign at_crc = act_r && (cnt_r == CNT_CRC);
  assign busy   = act_r && !at_crc;
  assign accept = start && !busy;

  assign cur_byte = at_crc ? crc_r : data_r[PAYLOAD_W-1 -: 8];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= 8'h05;
      node_r <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC: sync_r <= cfg_wdata;
        REG_NODE: node_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // Load the framed payload on accept, else advance one byte or, at the CRC byte, go idle
  always_comb begin
    act_nxt  = act_r;
    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    crc_nxt  = crc_r;
    if (accept) begin
      act_nxt  = 1'b1;
      cnt_nxt  = '0;
      data_nxt = {sync_r, node_r, WRITE_FLAG | {1'b0, in_reg_address}, in_write_value};
      crc_nxt  = CRC_INIT;
    end else if (act_r) begin
      if (at_crc) begin
        act_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_r + 1'b1;
        data_nxt = {data_r[PAYLOAD_W-9:0], 8'h00};
        crc_nxt  = crc8_feed(crc_r, cur_byte);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= act_r;
      olast_r <= at_crc;
    end
  end

  // Payload: shift register, running CRC and output byte
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    crc_r   <= crc_nxt;
    obyte_r <= cur_byte;
  end

  assign out_valid     = oval_r;
  assign out_byte      = obyte_r;
  assign out_last_byte = olast_r;

`ifndef ASSERT_OFF
  // The first beat of a datagram carries the sync byte captured at accept
  a_first_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 (out_valid && out_byte == $past(sync_r, 2)))
    else $error("first datagram beat is not the sync byte");

  // The last flag only marks a valid beat
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_byte |-> out_valid)
    else $error("last flag without a valid beat");

  // Beats of one datagram come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_byte) |=> out_valid)
    else $error("gap inside a datagram");

  // The CRC beat is shown only after busy was released for it
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_last_byte) |-> $past(!busy))
    else $error("CRC beat while busy");
`endif

endmodule

### bench/register_write_datagram_crc8_test.sv
// Self-checking bench for register_write_datagram_crc8: directed and random write requests,
// each predicted as an eight-beat datagram with CRC-8 and checked beat by beat.
// Depends on rwdc_pkg and the register_write_datagram_crc8 RTL.
module register_write_datagram_crc8_test;
  import rwdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 40;
  localparam int TAIL_CYCLES    = 12;

  typedef struct packed {
    byte_t data;
    logic  last;
  } dgram_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [6:0]           in_reg_address;
  logic [31:0]          in_write_value;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 out_last_byte;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  // Bench copy of the configuration registers
  byte_t       sync_setting;
  byte_t       node_setting;
  dgram_beat_t pending_beats[$];
  int          mismatch_count;
  int          quiet_cycles;
  // Percentage of offer cycles in which the sender holds start low
  int          sender_idle_pct;

  register_write_datagram_crc8 uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_reg_address (in_reg_address),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Advance the CRC over one byte, lsb first, register shifting toward bit 7
  function automatic byte_t crc8_next(input byte_t acc, input byte_t data_in);
    byte_t r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[7] ^ data_in[i]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Build the expected datagram for one request and queue its beats
  function automatic void predict_datagram(input logic [6:0] addr, input logic [31:0] val);
    byte_t       frame[8];
    byte_t       crc;
    dgram_beat_t beat;
    frame[0] = sync_setting;
    frame[1] = node_setting;
    frame[2] = {1'b0, addr} | WRITE_FLAG;
    frame[3] = val[31:24];
    frame[4] = val[23:16];
    frame[5] = val[15:8];
    frame[6] = val[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 7; i++) begin
      crc = crc8_next(crc, frame[i]);
    end
    frame[7] = crc;
    for (int i = 0; i < 8; i++) begin
      beat.data = frame[i];
      beat.last = (i == 7);
      pending_beats.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    end
  endtask

  // Check each output beat against the oldest expected beat
  always @(posedge clk) begin
    dgram_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_byte, 8'h00);
      end else begin
        want = pending_beats.pop_front();
        if (out_byte !== want.data) begin
          report_mismatch("out_byte", out_byte, want.data);
        end
        if (out_last_byte !== want.last) begin
          report_mismatch("out_last_byte", {7'd0, out_last_byte}, {7'd0, want.last});
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, idling at random, and hold it until the block takes it
  task automatic send_request(input logic [6:0] addr, input logic [31:0] val);
    logic taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      start          <= ($urandom_range(0, 99) >= sender_idle_pct);
      in_reg_address <= addr;
      in_write_value <= val;
      @(posedge clk);
      taken = start && !busy;
    end
    predict_datagram(addr, val);
  endtask

  // Drop start and wait for every expected beat to arrive
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_beats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write both registers while the block is idle
  task automatic write_settings(input byte_t sync_val, input byte_t node_val);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC;
    cfg_wdata <= sync_val;
    @(negedge clk);
    cfg_index <= REG_NODE;
    cfg_wdata <= node_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sync_setting = sync_val;
    node_setting = node_val;
  endtask

  task automatic test_reset_settings;
    send_request(7'h00, 32'h0000_0000);
    send_request(7'h7F, 32'hFFFF_FFFF);
    send_request(7'h22, 32'h0000_0007);
  endtask

  task automatic test_field_extremes;
    write_settings(8'h00, 8'h00);
    send_request(7'h00, 32'h0000_0000);
    send_request(7'h7F, 32'h0000_0000);
    send_request(7'h00, 32'hFFFF_FFFF);
    send_request(7'h55, 32'h8000_0000);
    send_request(7'h2A, 32'h0000_0001);
    write_settings(8'hFF, 8'hFF);
    send_request(7'h7F, 32'hFFFF_FFFF);
    send_request(7'h00, 32'hAAAA_AAAA);
    send_request(7'h7F, 32'h5555_5555);
    send_request(7'h01, 32'h0102_0408);
    write_settings(8'hA5, 8'h5A);
    send_request(7'h40, 32'hFF00_FF00);
    send_request(7'h3F, 32'h00FF_00FF);
    send_request(7'h12, 32'h1234_5678);
  endtask

  // Random requests with the sender idling idle_pct percent of the offer cycles
  task automatic test_random_traffic(input int idle_pct, input int count);
    logic [31:0] val;
    int          bit_pos;
    write_settings(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      bit_pos = $urandom_range(0, 31);
      case ($urandom_range(0, 7))
        0:       val = 32'h0000_0000;
        1:       val = 32'hFFFF_FFFF;
        2:       val = 32'h1 << bit_pos;
        3:       val = ~(32'h1 << bit_pos);
        default: val = $urandom;
      endcase
      send_request(7'($urandom_range(0, 127)), val);
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_reg_address  = '0;
    in_write_value  = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_SYNC;
    cfg_wdata       = '0;
    sync_setting    = 8'h05;
    node_setting    = 8'h00;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_field_extremes();
    test_random_traffic(13, 85);
    test_random_traffic(66, 85);
    test_random_traffic(0, 85);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
